>>> hw/rtl/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg)
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int SIZE_W = 33;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_CRIT  = 3'd2;
  localparam logic [2:0] KIND_CHECK = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_CRIT    = 3'd5;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_REGION_SIZE = 1'b1;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
    logic        critical;
  } entry_t;

  typedef struct packed {
    logic   we;
    entry_t data;
  } tbl_wr_t;

  localparam entry_t HEAD_ENTRY = '{offset: 32'd0, size: 32'd0, free: 1'b0, critical: 1'b1};

endpackage
`default_nettype wire

>>> hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: sequencer over the block table and result register.
//
// One request is in work at a time. Free, mark critical and check valid with an in-range
// address, and query used, scan the block table: the sequencer reads one table entry per
// cycle through the memory's single read port. Alloc first waits for the round-up unit,
// then scans up to N entries, where N is the number of blocks in the table, and an append
// then passes the S_TAIL and S_CHECK states for the end-of-data check.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] address,
  input  wire logic        include_freed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_address,
  output logic [2:0]       status,
  output logic             is_valid,
  output logic [31:0]      used_bytes
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] ALIGN_M1 = SIZE_W'(ALIGN_BYTES - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ROUND  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_TAIL   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t            state;
  logic [31:0]       region_base;
  logic [31:0]       region_size;
  logic [CNT_W-1:0]  count;
  logic [2:0]        kind_q;
  logic [31:0]       rel_q;
  logic              incl_q;
  logic [CNT_W-1:0]  iss;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  entry_t            last;
  logic [31:0]       total;
  logic [33:0]       next_off;
  tbl_wr_t           wr_q;
  logic [IDX_W-1:0]  wr_addr_q;
  logic [31:0]       pend_addr;
  logic [2:0]        pend_status;
  logic              pend_valid;
  logic [31:0]       pend_used;

  logic              accept;
  logic              in_range;
  logic              round_start;
  logic              round_done;
  logic [SIZE_W-1:0] sz;
  entry_t            ent;
  logic              fit;
  logic              match;
  logic              hit;
  logic              issue;
  logic              scan_end;
  logic              add_size;
  logic [32:0]       sum;
  logic [31:0]       data_addr;
  logic [34:0]       end_addr;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign in_range    = (address >= region_base) && ((address - region_base) <= region_size);
  assign round_start = accept && (kind == KIND_ALLOC);

  ffba_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
    .clk   (clk),
    .rst   (rst),
    .start (round_start),
    .value (SIZE_W'({1'b0, request_size}) + ALIGN_M1),
    .done  (round_done),
    .size  (sz)
  );

  ffba_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (iss[IDX_W-1:0]),
    .rd_data (ent),
    .wr      (wr_q),
    .wr_addr (wr_addr_q)
  );

  always_comb begin
    fit   = ent.free && ({1'b0, ent.size} >= sz);
    match = (({1'b0, ent.offset} + HDR33) == {1'b0, rel_q});
    case (kind_q) inside
      KIND_ALLOC:                        hit = rd_pend && fit;
      KIND_FREE, KIND_CRIT, KIND_CHECK:  hit = rd_pend && match;
      default:                           hit = 1'b0;
    endcase
    issue     = (state == S_SCAN) && !hit && (iss != count);
    scan_end  = (state == S_SCAN) && !rd_pend && (iss == count);
    add_size  = !ent.free || incl_q;
    sum       = {1'b0, total} + {1'b0, ent.size};
    data_addr = region_base + ent.offset + HDR32;
    end_addr  = {1'b0, next_off} + {2'b0, HDR33} + {2'b0, sz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= CNT_W'(1);
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      wr_q.we     <= 1'b0;
      region_base <= '0;
      region_size <= '0;
    end else begin
      wr_q.we <= 1'b0;
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= iss[IDX_W-1:0];
        iss    <= iss + 1'b1;
      end
      if (rd_pend) begin
        last <= ent;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REGION_BASE: region_base <= cfg_data;
          CFG_REGION_SIZE: region_size <= cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q      <= kind;
            rel_q       <= address - region_base;
            incl_q      <= include_freed;
            iss         <= '0;
            total       <= '0;
            pend_addr   <= '0;
            pend_status <= ST_OK;
            pend_valid  <= 1'b0;
            pend_used   <= '0;
            case (kind) inside
              KIND_ALLOC: state <= S_ROUND;
              KIND_FREE, KIND_CRIT: begin
                if (in_range) begin
                  state <= S_SCAN;
                end else begin
                  pend_status <= ST_INVALID;
                  state       <= S_FINISH;
                end
              end
              KIND_CHECK: state <= in_range ? S_SCAN : S_FINISH;
              KIND_QUERY: state <= S_SCAN;
              default: begin
                pend_status <= ST_INVALID;
                state       <= S_FINISH;
              end
            endcase
          end
        end

        S_ROUND: begin
          if (round_done) begin
            if (sz == '0) begin
              pend_status <= ST_ZERO;
              state       <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (rd_pend && (kind_q == KIND_QUERY) && add_size) begin
            total <= sum[32] ? '1 : sum[31:0];
          end
          if (hit) begin
            wr_addr_q <= rd_idx;
            wr_q.data <= ent;
            case (kind_q) inside
              KIND_ALLOC: begin
                wr_q.we            <= 1'b1;
                wr_q.data.free     <= 1'b0;
                wr_q.data.critical <= 1'b0;
                pend_addr          <= data_addr;
              end
              KIND_FREE: begin
                if (ent.critical) begin
                  pend_status <= ST_CRIT;
                end else if (ent.free) begin
                  pend_status <= ST_FREED;
                end else begin
                  wr_q.we        <= 1'b1;
                  wr_q.data.free <= 1'b1;
                end
              end
              KIND_CRIT: begin
                wr_q.we            <= 1'b1;
                wr_q.data.critical <= 1'b1;
              end
              default: pend_valid <= 1'b1;
            endcase
            state <= S_FINISH;
          end else if (scan_end) begin
            case (kind_q) inside
              KIND_ALLOC: begin
                if (count == CNT_W'(MAX_BLOCKS)) begin
                  pend_status <= ST_OOM;
                  state       <= S_FINISH;
                end else begin
                  state <= S_TAIL;
                end
              end
              KIND_FREE, KIND_CRIT: begin
                pend_status <= ST_INVALID;
                state       <= S_FINISH;
              end
              KIND_QUERY: begin
                pend_used <= total;
                state     <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_TAIL: begin
          next_off <= {2'b0, last.offset} + HDR34 + {2'b0, last.size};
          state    <= S_CHECK;
        end

        S_CHECK: begin
          if (end_addr > {3'b0, region_size}) begin
            pend_status <= ST_OOM;
          end else begin
            wr_q.we            <= 1'b1;
            wr_addr_q          <= count[IDX_W-1:0];
            wr_q.data.offset   <= next_off[31:0];
            wr_q.data.size     <= sz[31:0];
            wr_q.data.free     <= 1'b0;
            wr_q.data.critical <= 1'b0;
            count              <= count + 1'b1;
            pend_addr          <= region_base + next_off[31:0] + HDR32;
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            result_address <= pend_addr;
            status         <= pend_status;
            is_valid       <= pend_valid;
            used_bytes     <= pend_used;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `FFBA_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted transfer left sequencer idle")
  `FFBA_ASSERT_IMPL(a_wr_in_table, wr_q.we, CNT_W'(wr_addr_q) < count, "table write past block count")
  `FFBA_ASSERT_IMPL(a_count_range, 1'b1, (count != '0) && (count <= CNT_W'(MAX_BLOCKS)), "block count out of range")
  `FFBA_ASSERT_IMPL(a_rd_in_scan, rd_pend, $past(state) == S_SCAN, "table read outside scan")

endmodule
`default_nettype wire

>>> hw/rtl/ffba_round.sv
// Round-up of a request size to the alignment by reciprocal multiplication.
`default_nettype none
module ffba_round
  import ffba_pkg::*;
#(
  parameter int ALIGN_BYTES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SIZE_W-1:0] value,
  output logic                   done,
  output logic      [SIZE_W-1:0] size
);

  localparam int HALF_W = (SIZE_W + 2) / 2;
  localparam int PART_W = SIZE_W + HALF_W;
  localparam int PROD_W = SIZE_W + 2 * HALF_W;
  localparam int SHIFT  = SIZE_W + $clog2(ALIGN_BYTES);
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
  localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];
  localparam logic [SIZE_W-1:0] ALIGN_K  = SIZE_W'(ALIGN_BYTES);

  logic [3:0]        stage;
  logic [SIZE_W-1:0] val_q;
  logic [PART_W-1:0] prod_lo;
  logic [PART_W-1:0] prod_hi;
  logic [PROD_W-1:0] prod;
  logic [SIZE_W-1:0] quot;

  assign prod = {prod_hi, {HALF_W{1'b0}}} + PROD_W'(prod_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[2:0], start};
      done  <= stage[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_q <= value;
    end
    if (stage[0]) begin
      prod_lo <= PART_W'(val_q) * PART_W'(RECIP_LO);
    end
    if (stage[1]) begin
      prod_hi <= PART_W'(val_q) * PART_W'(RECIP_HI);
    end
    if (stage[2]) begin
      quot <= SIZE_W'(prod >> SHIFT);
    end
    if (stage[3]) begin
      size <= quot * ALIGN_K;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ffba_table.sv
// Block table memory with one write port and a registered read port.
`default_nettype none
module ffba_table
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
  output entry_t                             rd_data,
  input  wire tbl_wr_t                       wr,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] wr_addr
);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;
  logic   rd_head;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_head <= (rd_addr == '0);
    end
  end

  assign rd_data = rd_head ? HEAD_ENTRY : rd_q;

endmodule
`default_nettype wire

>>> bench/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit block allocator: directed and random traffic.
`timescale 1ns / 100ps
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int BLOCKS = 64;
  localparam int ALIGN = 8;
  localparam int HDR = 32;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] nbytes;
    logic [31:0] addr;
    logic        with_freed;
  } request_t;

  typedef struct packed {
    logic [31:0] data_addr;
    logic [2:0]  code;
    logic        hit;
    logic [31:0] used;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [31:0] request_size = '0;
  logic [31:0] address = '0;
  logic        include_freed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_address;
  logic [2:0]  status;
  logic        is_valid;
  logic [31:0] used_bytes;

  logic [31:0] region_base_q = '0;
  logic [31:0] region_size_q = '0;
  entry_t      tbl [BLOCKS];
  int          tbl_count = 1;
  outcome_t    due_answers [$];
  int          mismatch_count = 0;

  int          burst_left = 0;
  bit          steady_sender = 1'b0;
  bit          quiet_receiver = 1'b0;
  logic        hold_flip = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          stall_span = 0;
  int          stall_pct = 0;

  first_fit_block_allocator #(
    .MAX_BLOCKS  (BLOCKS),
    .ALIGN_BYTES (ALIGN),
    .HEADER_BYTES(HDR)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .request_size  (request_size),
    .address       (address),
    .include_freed (include_freed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_address(result_address),
    .status        (status),
    .is_valid      (is_valid),
    .used_bytes    (used_bytes)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] block_addr(int i);
    return region_base_q + tbl[i].offset + HDR;
  endfunction

  function automatic int find_block(logic [31:0] a);
    logic [63:0] lo, hi;
    lo = 64'(region_base_q);
    hi = lo + 64'(region_size_q);
    if (64'(a) < lo || 64'(a) > hi) return -1;
    for (int i = 0; i < tbl_count; i++)
      if (64'(tbl[i].offset) + HDR == 64'(a) - lo) return i;
    return -1;
  endfunction

  function automatic logic [31:0] room_left();
    logic [63:0] used_end;
    used_end = 64'(tbl[tbl_count - 1].offset) + 2 * HDR + 64'(tbl[tbl_count - 1].size);
    return (used_end < 64'(region_size_q)) ? 32'(64'(region_size_q) - used_end) : 32'd1;
  endfunction

  function automatic outcome_t alloc_block(logic [31:0] nbytes);
    outcome_t    o;
    logic [63:0] need, next_off;
    int          last;
    o = '0;
    need = ((64'(nbytes) + ALIGN - 1) / ALIGN) * ALIGN;
    if (need == 0) begin
      o.code = ST_ZERO;
      return o;
    end
    for (int i = 0; i < tbl_count; i++)
      if (tbl[i].free && 64'(tbl[i].size) >= need) begin
        tbl[i].free = 1'b0;
        tbl[i].critical = 1'b0;
        o.data_addr = block_addr(i);
        return o;
      end
    if (tbl_count >= BLOCKS) begin
      o.code = ST_OOM;
      return o;
    end
    last = tbl_count - 1;
    next_off = 64'(tbl[last].offset) + HDR + 64'(tbl[last].size);
    if (next_off + HDR + need > 64'(region_size_q)) begin
      o.code = ST_OOM;
      return o;
    end
    tbl[tbl_count] = '{offset: next_off[31:0], size: need[31:0], free: 1'b0, critical: 1'b0};
    o.data_addr = block_addr(tbl_count);
    tbl_count++;
    return o;
  endfunction

  function automatic outcome_t run_table_op(request_t r);
    outcome_t    o;
    int          hit;
    logic [63:0] total;
    o = '0;
    case (r.op)
      KIND_ALLOC: o = alloc_block(r.nbytes);
      KIND_FREE: begin
        hit = find_block(r.addr);
        if (hit < 0) o.code = ST_INVALID;
        else if (tbl[hit].critical) o.code = ST_CRIT;
        else if (tbl[hit].free) o.code = ST_FREED;
        else tbl[hit].free = 1'b1;
      end
      KIND_CRIT: begin
        hit = find_block(r.addr);
        if (hit < 0) o.code = ST_INVALID;
        else tbl[hit].critical = 1'b1;
      end
      KIND_CHECK: o.hit = (find_block(r.addr) >= 0);
      KIND_QUERY: begin
        total = '0;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl[i].free || r.with_freed) total += 64'(tbl[i].size);
          if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        end
        o.used = total[31:0];
      end
      default: o.code = ST_INVALID;
    endcase
    return o;
  endfunction

  function automatic request_t make_req(logic [2:0] op, logic [31:0] nbytes, logic [31:0] addr,
                                        logic with_freed);
    request_t r;
    r.op = op;
    r.nbytes = nbytes;
    r.addr = addr;
    r.with_freed = with_freed;
    return r;
  endfunction

  function automatic logic [31:0] random_size();
    case ($urandom_range(19))
      0: return $urandom_range(7);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(15);
      3: return room_left();
      default: return $urandom_range(160, 1);
    endcase
  endfunction

  function automatic logic [31:0] random_address();
    case ($urandom_range(19))
      0, 1: return $urandom;
      2: return region_base_q - 1;
      3: return region_base_q + region_size_q;
      4: return region_base_q + region_size_q + 1;
      5: return region_base_q + $urandom_range(region_size_q);
      6: return block_addr($urandom_range(tbl_count - 1)) + $urandom_range(7, 1);
      default: return block_addr($urandom_range(tbl_count - 1));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 34) r.op = KIND_ALLOC;
    else if (pick < 58) r.op = KIND_FREE;
    else if (pick < 66) r.op = KIND_CRIT;
    else if (pick < 80) r.op = KIND_CHECK;
    else if (pick < 94) r.op = KIND_QUERY;
    else r.op = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    r.nbytes = random_size();
    r.addr = random_address();
    r.with_freed = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  task automatic pace_sender();
    int gap;
    if (steady_sender) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(6);
    gap = ($urandom_range(3) == 0) ? $urandom_range(120, 20) : $urandom_range(6, 1);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_request(input request_t r);
    in_valid <= 1'b1;
    kind <= r.op;
    request_size <= r.nbytes;
    address <= r.addr;
    include_freed <= r.with_freed;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    due_answers.push_back(run_table_op(r));
    pace_sender();
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_REGION_BASE) region_base_q = val;
    else region_size_q = val;
  endtask

  task automatic set_region(input logic [31:0] base, input logic [31:0] size);
    drain_answers();
    @(posedge clk);
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SIZE, size);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_request(make_req(KIND_QUERY, '0, '0, 1'b1));
    send_request(make_req(KIND_ALLOC, 32'd1, '0, 1'b0));
    send_request(make_req(KIND_CHECK, '0, block_addr(0), 1'b0));
    send_request(make_req(KIND_FREE, '0, block_addr(0), 1'b0));
  endtask

  task automatic test_small_region();
    logic [31:0] b1, b2;
    int          k;
    set_region(32'h0000_1000, 32'h0000_0200);
    send_request(make_req(KIND_ALLOC, 32'd1, '0, 1'b0));
    b1 = block_addr(tbl_count - 1);
    send_request(make_req(KIND_ALLOC, 32'd13, '0, 1'b0));
    b2 = block_addr(tbl_count - 1);
    send_request(make_req(KIND_ALLOC, 32'd8, '0, 1'b0));
    send_request(make_req(KIND_FREE, '0, block_addr(0), 1'b0));
    send_request(make_req(KIND_FREE, '0, b1, 1'b0));
    send_request(make_req(KIND_FREE, '0, b1, 1'b0));
    send_request(make_req(KIND_CRIT, '0, b1, 1'b0));
    send_request(make_req(KIND_FREE, '0, b1, 1'b0));
    send_request(make_req(KIND_CHECK, '0, b1, 1'b0));
    send_request(make_req(KIND_CHECK, '0, b1 + 1, 1'b0));
    send_request(make_req(KIND_QUERY, '0, '0, 1'b0));
    send_request(make_req(KIND_QUERY, '0, '0, 1'b1));
    send_request(make_req(KIND_FREE, '0, b2, 1'b0));
    send_request(make_req(KIND_ALLOC, 32'd16, '0, 1'b0));
    send_request(make_req(KIND_ALLOC, 32'd5, '0, 1'b0));
    send_request(make_req(KIND_FREE, '0, b1, 1'b0));
    send_request(make_req(KIND_ALLOC, room_left(), '0, 1'b0));
    send_request(make_req(KIND_ALLOC, 32'd1, '0, 1'b0));
    send_request(make_req(KIND_ALLOC, 32'hFFFF_FFFF, '0, 1'b0));
    send_request(make_req(KIND_ALLOC, 32'd0, '0, 1'b0));
    send_request(make_req(KIND_CRIT, '0, region_base_q + region_size_q + 1, 1'b0));
    for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_request(make_req(3'(k), $urandom, $urandom, 1'b1));
  endtask

  task automatic test_random_traffic(input logic [31:0] base, input logic [31:0] size,
                                     input int count);
    int n;
    set_region(base, size);
    for (n = 0; n < count; n++) send_request(random_request());
  endtask

  task automatic test_input_backpressure();
    int n;
    steady_sender = 1'b1;
    hold_flip <= ~hold_flip;
    for (n = 0; n < 40; n++) send_request(random_request());
    steady_sender = 1'b0;
  endtask

  task automatic test_full_table();
    int tries;
    set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
    tries = 0;
    while (tbl_count < BLOCKS && tries < 200) begin
      send_request(make_req(KIND_ALLOC, $urandom_range(64, 1), '0, 1'b0));
      tries++;
    end
    send_request(make_req(KIND_ALLOC, 32'hFFFF_FFF0, '0, 1'b0));
    send_request(make_req(KIND_QUERY, '0, '0, 1'b0));
  endtask

  task automatic test_streaming_extremes();
    steady_sender = 1'b1;
    quiet_receiver = 1'b1;
    test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
    steady_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
    end
    if (stall_span == 0) begin
      stall_span = $urandom_range(300, 20);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_span--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_receiver && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (due_answers.size() == 0) begin
        flag_mismatch("result transfer with nothing outstanding");
      end else begin
        want = due_answers.pop_front();
        if (result_address !== want.data_addr)
          flag_mismatch($sformatf("result_address: expected %h, got %h",
                                  want.data_addr, result_address));
        if (status !== want.code)
          flag_mismatch($sformatf("status: expected %0d, got %0d", want.code, status));
        if (is_valid !== want.hit)
          flag_mismatch($sformatf("is_valid: expected %0d, got %0d", want.hit, is_valid));
        if (used_bytes !== want.used)
          flag_mismatch($sformatf("used_bytes: expected %h, got %h", want.used, used_bytes));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    tbl[0] = HEAD_ENTRY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_small_region();
    test_random_traffic(32'h0001_0000, 32'd4096, 300);
    test_input_backpressure();
    test_full_table();
    test_random_traffic(32'hFFFF_F000, 32'hFFFF_FFFF, 350);
    test_streaming_extremes();
    test_random_traffic(32'h0000_0000, 32'h0000_0000, 80);
    test_random_traffic($urandom, $urandom | 32'h8000_0000, 300);
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
